### hw/rtl/ppfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppfc_pkg;

    // Palette geometry.
    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_DEPTH);

    // Operation codes carried by an input item.
    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_CONVERT     = 1'b1;

    // PNG colour types.
    localparam logic [2:0] CT_GRAY       = 3'd0;
    localparam logic [2:0] CT_RGB        = 3'd2;
    localparam logic [2:0] CT_INDEXED    = 3'd3;
    localparam logic [2:0] CT_GRAY_ALPHA = 3'd4;
    localparam logic [2:0] CT_RGBA       = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] CFG_SRC_BIT_DEPTH   = 3'd0;
    localparam logic [2:0] CFG_SRC_COLOR_TYPE  = 3'd1;
    localparam logic [2:0] CFG_DST_BIT_DEPTH   = 3'd2;
    localparam logic [2:0] CFG_DST_COLOR_TYPE  = 3'd3;
    localparam logic [2:0] CFG_PALETTE_PRESENT = 3'd4;
    localparam logic [2:0] CFG_PALETTE_COUNT   = 3'd5;
    localparam logic [2:0] CFG_ALPHA_COUNT     = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    // Reciprocal of three for sums up to 765: floor(x / 3) = (x * 683) >> 11.
    localparam logic [9:0] RECIP3     = 10'd683;
    localparam int         RECIP3_SHR = 11;

    localparam logic [9:0] GRAY1_THRESHOLD = 10'h180;

    typedef struct packed {
        logic        op;
        logic [63:0] pixel_in;
        logic [7:0]  table_index;
        logic [23:0] table_color;
        logic [7:0]  table_alpha;
    } t_in_item;

    typedef struct packed {
        logic [63:0] pixel_out;
        logic        format_error;
    } t_out_item;

    typedef struct packed {
        logic [4:0] src_bit_depth;
        logic [2:0] src_color_type;
        logic [4:0] dst_bit_depth;
        logic [2:0] dst_color_type;
        logic       palette_present;
        logic [8:0] palette_count;
        logic [8:0] alpha_count;
    } t_cfg;

    // Pixel size in bits; zero marks an unsupported format.
    function automatic logic [6:0] pixel_bits(input logic [4:0] depth, input logic [2:0] ct);
        logic d8_16;
        logic low;
        logic [6:0] bits;
        d8_16 = (depth == 5'd8) || (depth == 5'd16);
        low   = (depth == 5'd1) || (depth == 5'd2) || (depth == 5'd4) || (depth == 5'd8);
        bits  = 7'd0;
        case (ct)
            CT_GRAY:       bits = (low || depth == 5'd16) ? {2'b00, depth} : 7'd0;
            CT_INDEXED:    bits = low ? {2'b00, depth} : 7'd0;
            CT_RGB:        bits = d8_16 ? ((depth == 5'd8) ? 7'd24 : 7'd48) : 7'd0;
            CT_GRAY_ALPHA: bits = d8_16 ? ((depth == 5'd8) ? 7'd16 : 7'd32) : 7'd0;
            CT_RGBA:       bits = d8_16 ? ((depth == 5'd8) ? 7'd32 : 7'd64) : 7'd0;
            default:       bits = 7'd0;
        endcase
        return bits;
    endfunction

    // Mask of the low bits that a pixel of the given size occupies.
    function automatic logic [63:0] pixel_mask(input logic [6:0] bits);
        logic [63:0] m;
        if (bits >= 7'd64) begin
            m = '1;
        end else begin
            m = (64'd1 << bits[5:0]) - 64'd1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/png_pixel_format_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+------------------------------
// in       | input     | i_in_valid / o_in_ready    | i_in_data  (ppfc_pkg::t_in_item)
// out      | output    | o_out_valid / i_out_ready  | o_out_data (ppfc_pkg::t_out_item)
// cfg      | input     | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One item is accepted per cycle while o_in_ready is high. For a convert item
// the palette is read as the item is accepted, the next stage registers the
// RGBA8 value and the channel sum, and the output register the gray divide
// and repacking. A palette write item is written as it is accepted and yields
// no result.
// Reset clears the pipeline valid bits and sets the configuration to RGBA8 in
// and out, with the palette flag and counts at zero; the palette itself is
// undefined until written. Each stage holds when the one after it is full and
// stalled, so a waiting result does not stop new items filling empty stages.

module png_pixel_format_converter (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire ppfc_pkg::t_in_item                    i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output ppfc_pkg::t_out_item                        o_out_data,
    input  wire logic                                  i_cfg_we,
    input  wire logic [ppfc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [ppfc_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // Configuration registers.
    ppfc_pkg::t_cfg r_cfg;

    // Pipeline state.
    logic        r_s1_valid;
    logic [63:0] r_s1_pixel;
    logic [7:0]  r_s1_ix;
    logic        r_s2_valid;
    logic [31:0] r_s2_rgba;
    logic [9:0]  r_s2_sum;
    logic [63:0] r_s2_pass;
    logic        r_out_valid;
    ppfc_pkg::t_out_item r_out;

    // Handshake and stage advance terms.
    logic in_acc;
    logic out_free;
    logic s3_adv;
    logic s2_free;
    logic s2_adv;
    logic s1_free;
    logic is_convert;

    // Format decode from configuration.
    logic [6:0]  src_bits;
    logic [6:0]  dst_bits;
    logic        fmt_error;
    logic        fmt_same;

    // Palette access.
    logic [7:0]  ix_in;
    logic        ram_we;
    logic        ram_re;
    logic [31:0] ram_rdata;

    logic [31:0] rd_rgba;
    logic [9:0]  rd_sum;
    logic [63:0] wr_pixel;

    // Stage control: each stage loads when it is empty or its item moves on to the next.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s3_adv     = r_s2_valid && out_free;
    assign s2_free    = !r_s2_valid || s3_adv;
    assign s2_adv     = r_s1_valid && s2_free;
    assign s1_free    = !r_s1_valid || s2_adv;
    assign o_in_ready = s1_free;
    assign in_acc     = i_in_valid && s1_free;
    assign is_convert = (i_in_data.op == ppfc_pkg::OP_CONVERT);

    assign src_bits  = ppfc_pkg::pixel_bits(r_cfg.src_bit_depth, r_cfg.src_color_type);
    assign dst_bits  = ppfc_pkg::pixel_bits(r_cfg.dst_bit_depth, r_cfg.dst_color_type);
    assign fmt_error = (src_bits == 7'd0) || (dst_bits == 7'd0);
    assign fmt_same  = (r_cfg.src_bit_depth == r_cfg.dst_bit_depth) &&
                       (r_cfg.src_color_type == r_cfg.dst_color_type);

    // The palette index is the low source-depth bits of the pixel.
    always_comb begin
        case (r_cfg.src_bit_depth)
            5'd1:    ix_in = {7'd0, i_in_data.pixel_in[0]};
            5'd2:    ix_in = {6'd0, i_in_data.pixel_in[1:0]};
            5'd4:    ix_in = {4'd0, i_in_data.pixel_in[3:0]};
            default: ix_in = i_in_data.pixel_in[7:0];
        endcase
    end

    // Writes and reads of the palette both happen as an item is accepted, so
    // a read always sees every write of an earlier item. Writes past the
    // palette depth are dropped.
    assign ram_we = in_acc && !is_convert &&
                    ({1'b0, i_in_data.table_index} < ppfc_pkg::PAL_LIMIT);
    assign ram_re = in_acc && is_convert;

    ppfc_palette_ram #(
        .DEPTH (ppfc_pkg::PALETTE_DEPTH),
        .WIDTH (32)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in_data.table_index[ppfc_pkg::PAL_AW-1:0]),
        .i_wdata ({i_in_data.table_color, i_in_data.table_alpha}),
        .i_re    (ram_re),
        .i_raddr (ix_in[ppfc_pkg::PAL_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    ppfc_reader u_reader (
        .i_pixel (r_s1_pixel),
        .i_ix    (r_s1_ix),
        .i_rdata (ram_rdata),
        .i_cfg   (r_cfg),
        .o_rgba  (rd_rgba),
        .o_sum   (rd_sum)
    );

    ppfc_writer u_writer (
        .i_rgba  (r_s2_rgba),
        .i_sum   (r_s2_sum),
        .i_cfg   (r_cfg),
        .o_pixel (wr_pixel)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_bit_depth   <= 5'd8;
            r_cfg.src_color_type  <= ppfc_pkg::CT_RGBA;
            r_cfg.dst_bit_depth   <= 5'd8;
            r_cfg.dst_color_type  <= ppfc_pkg::CT_RGBA;
            r_cfg.palette_present <= 1'b0;
            r_cfg.palette_count   <= 9'd0;
            r_cfg.alpha_count     <= 9'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppfc_pkg::CFG_SRC_BIT_DEPTH:   r_cfg.src_bit_depth   <= i_cfg_data[4:0];
                ppfc_pkg::CFG_SRC_COLOR_TYPE:  r_cfg.src_color_type  <= i_cfg_data[2:0];
                ppfc_pkg::CFG_DST_BIT_DEPTH:   r_cfg.dst_bit_depth   <= i_cfg_data[4:0];
                ppfc_pkg::CFG_DST_COLOR_TYPE:  r_cfg.dst_color_type  <= i_cfg_data[2:0];
                ppfc_pkg::CFG_PALETTE_PRESENT: r_cfg.palette_present <= i_cfg_data[0];
                ppfc_pkg::CFG_PALETTE_COUNT:   r_cfg.palette_count   <= i_cfg_data;
                ppfc_pkg::CFG_ALPHA_COUNT:     r_cfg.alpha_count     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= in_acc && is_convert;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_s1_pixel <= i_in_data.pixel_in;
            r_s1_ix    <= ix_in;
        end
        if (s2_adv) begin
            r_s2_rgba <= rd_rgba;
            r_s2_sum  <= rd_sum;
            r_s2_pass <= r_s1_pixel & ppfc_pkg::pixel_mask(src_bits);
        end
        if (s3_adv) begin
            if (fmt_error) begin
                r_out.pixel_out    <= 64'd0;
                r_out.format_error <= 1'b1;
            end else begin
                r_out.pixel_out    <= fmt_same ? r_s2_pass : wr_pixel;
                r_out.format_error <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A palette write never enters the conversion pipeline.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_convert) |=> !r_s1_valid)
        else $error("palette write item entered the pipeline");

    // The palette is never read and written in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("palette read and write collide");

    // A blocked first stage keeps its item and its pixel.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_adv) |=> (r_s1_valid && $stable(r_s1_pixel)))
        else $error("first stage lost its item while blocked");

    // An error result carries an all-zero pixel.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.format_error) |-> (r_out.pixel_out == 64'd0))
        else $error("format error result with nonzero pixel");
`endif

endmodule

`default_nettype wire

### hw/rtl/ppfc_palette_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ppfc_palette_ram #(
    parameter int DEPTH  = 256,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while the read enable is low.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hw/rtl/ppfc_reader.sv
`timescale 1ns / 1ps
`default_nettype none

module ppfc_reader (
    input  wire logic              [63:0] i_pixel,
    input  wire logic              [7:0]  i_ix,
    input  wire logic              [31:0] i_rdata,
    input  wire ppfc_pkg::t_cfg           i_cfg,
    output logic                   [31:0] o_rgba,
    output logic                   [9:0]  o_sum
);

    function automatic logic [31:0] gray_rgba(input logic [7:0] y);
        return {y, y, y, 8'hff};
    endfunction

    logic        ix_in_table;
    logic        rgb_ok;
    logic        alpha_ok;
    logic [7:0]  y;
    logic [31:0] rgba;

    assign ix_in_table = ({1'b0, i_ix} < ppfc_pkg::PAL_LIMIT);
    assign rgb_ok      = ix_in_table && ({1'b0, i_ix} < i_cfg.palette_count);
    assign alpha_ok    = ix_in_table && ({1'b0, i_ix} < i_cfg.alpha_count);

    always_comb begin
        y    = 8'h00;
        rgba = 32'h0000_00ff;
        if (i_cfg.src_color_type == ppfc_pkg::CT_INDEXED && i_cfg.palette_present) begin
            rgba[31:8] = rgb_ok ? i_rdata[31:8] : 24'h000000;
            rgba[7:0]  = alpha_ok ? i_rdata[7:0] : 8'hff;
        end else begin
            case (i_cfg.src_color_type)
                ppfc_pkg::CT_GRAY, ppfc_pkg::CT_INDEXED: begin
                    case (i_cfg.src_bit_depth)
                        5'd1:    y = {8{i_pixel[0]}};
                        5'd2:    y = {4{i_pixel[1:0]}};
                        5'd4:    y = {2{i_pixel[3:0]}};
                        5'd8:    y = i_pixel[7:0];
                        default: y = i_pixel[15:8];
                    endcase
                    rgba = gray_rgba(y);
                end
                ppfc_pkg::CT_RGB: begin
                    if (i_cfg.src_bit_depth == 5'd8) begin
                        rgba = {i_pixel[23:0], 8'hff};
                    end else begin
                        rgba = {i_pixel[47:40], i_pixel[31:24], i_pixel[15:8], 8'hff};
                    end
                end
                ppfc_pkg::CT_GRAY_ALPHA: begin
                    if (i_cfg.src_bit_depth == 5'd8) begin
                        rgba = {i_pixel[15:8], i_pixel[15:8], i_pixel[15:8], i_pixel[7:0]};
                    end else begin
                        rgba = {i_pixel[31:24], i_pixel[31:24], i_pixel[31:24], i_pixel[15:8]};
                    end
                end
                default: begin
                    if (i_cfg.src_bit_depth == 5'd8) begin
                        rgba = i_pixel[31:0];
                    end else begin
                        rgba = {i_pixel[63:56], i_pixel[47:40], i_pixel[31:24], i_pixel[15:8]};
                    end
                end
            endcase
        end
    end

    assign o_rgba = rgba;
    assign o_sum  = {2'b00, rgba[31:24]} + {2'b00, rgba[23:16]} + {2'b00, rgba[15:8]};

endmodule

`default_nettype wire

### hw/rtl/ppfc_writer.sv
`timescale 1ns / 1ps
`default_nettype none

module ppfc_writer (
    input  wire logic              [31:0] i_rgba,
    input  wire logic              [9:0]  i_sum,
    input  wire ppfc_pkg::t_cfg           i_cfg,
    output logic                   [63:0] o_pixel
);

    function automatic logic [15:0] dup16(input logic [7:0] v);
        return {v, v};
    endfunction

    logic [19:0] prod;
    logic [7:0]  y;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        d8;

    // Division of the channel sum by three as a multiply by the reciprocal.
    assign prod = i_sum * ppfc_pkg::RECIP3;
    assign y    = prod[ppfc_pkg::RECIP3_SHR +: 8];
    assign r    = i_rgba[31:24];
    assign g    = i_rgba[23:16];
    assign b    = i_rgba[15:8];
    assign a    = i_rgba[7:0];
    assign d8   = (i_cfg.dst_bit_depth == 5'd8);

    always_comb begin
        o_pixel = 64'd0;
        case (i_cfg.dst_color_type)
            ppfc_pkg::CT_GRAY, ppfc_pkg::CT_INDEXED: begin
                case (i_cfg.dst_bit_depth)
                    5'd1:    o_pixel = {63'd0, (i_sum >= ppfc_pkg::GRAY1_THRESHOLD)};
                    5'd2:    o_pixel = {62'd0, y[7:6]};
                    5'd4:    o_pixel = {60'd0, y[7:4]};
                    5'd8:    o_pixel = {56'd0, y};
                    default: o_pixel = {48'd0, dup16(y)};
                endcase
            end
            ppfc_pkg::CT_RGB: begin
                if (d8) begin
                    o_pixel = {40'd0, r, g, b};
                end else begin
                    o_pixel = {16'd0, dup16(r), dup16(g), dup16(b)};
                end
            end
            ppfc_pkg::CT_GRAY_ALPHA: begin
                if (d8) begin
                    o_pixel = {48'd0, y, a};
                end else begin
                    o_pixel = {32'd0, dup16(y), dup16(a)};
                end
            end
            default: begin
                if (d8) begin
                    o_pixel = {32'd0, i_rgba};
                end else begin
                    o_pixel = {dup16(r), dup16(g), dup16(b), dup16(a)};
                end
            end
        endcase
    end

endmodule

`default_nettype wire

### test/png_pixel_format_converter_tb.sv
`timescale 1ns / 1ps

module png_pixel_format_converter_tb;

    // Colour type code with no PNG meaning, used to provoke a format error.
    localparam logic [2:0] CT_RESERVED = 3'd5;

    // Idle cycles after the last expected result before the driver moves on.
    // The block is three stages deep, so a palette write item that yields no
    // result is long gone by then.
    localparam int DRAIN_SETTLE = 8;

    // Run limit in ns, far beyond the slowest correct run.
    localparam int RUN_LIMIT_NS = 5_000_000;

    typedef enum logic [1:0] {
        CMD_ITEM,
        CMD_REG,
        CMD_DRAIN,
        CMD_MODE
    } t_cmd_kind;

    typedef enum logic [1:0] {
        MODE_FLAT,
        MODE_SEND_GAPS,
        MODE_RECV_STALLS,
        MODE_BOTH
    } t_idle_mode;

    typedef struct packed {
        t_cmd_kind          kind;
        ppfc_pkg::t_in_item item;
        logic [2:0]         reg_idx;
        logic [8:0]         reg_val;
        t_idle_mode         mode;
    } t_cmd;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    ppfc_pkg::t_in_item  in_data = '0;
    logic                out_ready = 1'b0;
    logic                cfg_we = 1'b0;
    logic [2:0]          cfg_index = '0;
    logic [8:0]          cfg_data = '0;
    logic                in_ready;
    logic                out_valid;
    ppfc_pkg::t_out_item out_data;

    // Commands for the driver, filled once at time zero.
    t_cmd                pixel_cmds[$];
    // Predicted results, oldest first.
    ppfc_pkg::t_out_item expected_pixels[$];

    // Copy of the block's configuration and palette, kept by the monitor.
    ppfc_pkg::t_cfg      cfg_mirror;
    logic [31:0]         palette_mirror [0:ppfc_pkg::PALETTE_DEPTH-1];

    t_idle_mode  idle_mode = MODE_FLAT;
    int          outstanding = 0;
    logic        feed_idle = 1'b0;
    int          err_cnt = 0;
    int          result_cnt = 0;

    // Driver working state.
    logic               drain_on = 1'b0;
    int                 settle_left = 0;
    logic               nx_valid;
    ppfc_pkg::t_in_item nx_item;
    logic               nx_we;
    logic [2:0]         nx_idx;
    logic [8:0]         nx_val;
    t_idle_mode         nx_mode;
    logic               sender_gap;

    // Monitor working state.
    ppfc_pkg::t_out_item want;

    png_pixel_format_converter uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // Bits in one pixel of the given format; zero when the format is not
    // one that PNG allows.
    function automatic int format_width(input logic [4:0] depth, input logic [2:0] ct);
        logic sub8;
        logic wide;
        int   w;
        sub8 = (depth == 5'd1) || (depth == 5'd2) || (depth == 5'd4) || (depth == 5'd8);
        wide = (depth == 5'd8) || (depth == 5'd16);
        w = 0;
        case (ct)
            ppfc_pkg::CT_GRAY:       w = (sub8 || depth == 5'd16) ? int'(depth) : 0;
            ppfc_pkg::CT_INDEXED:    w = sub8 ? int'(depth) : 0;
            ppfc_pkg::CT_RGB:        w = wide ? 3 * int'(depth) : 0;
            ppfc_pkg::CT_GRAY_ALPHA: w = wide ? 2 * int'(depth) : 0;
            ppfc_pkg::CT_RGBA:       w = wide ? 4 * int'(depth) : 0;
            default:                 w = 0;
        endcase
        return w;
    endfunction

    // Source pixel to the RGBA8 intermediate, red in the top byte.
    function automatic logic [31:0] unpack_rgba8(input logic [63:0] pix);
        logic [7:0]  ix;
        logic [23:0] rgb;
        logic [7:0]  a;
        logic [7:0]  y;
        logic        d8;
        logic [31:0] c;
        d8 = (cfg_mirror.src_bit_depth == 5'd8);
        rgb = '0;
        a = 8'hff;
        y = '0;
        c = '0;
        if (cfg_mirror.src_color_type == ppfc_pkg::CT_INDEXED && cfg_mirror.palette_present) begin
            // Entries past the colour count read as black, past the alpha
            // count as opaque.
            ix = pix[7:0] & ~(8'hff << cfg_mirror.src_bit_depth);
            if ({1'b0, ix} < cfg_mirror.palette_count) begin
                rgb = palette_mirror[ix][31:8];
            end
            if ({1'b0, ix} < cfg_mirror.alpha_count) begin
                a = palette_mirror[ix][7:0];
            end
            c = {rgb, a};
        end else begin
            case (cfg_mirror.src_color_type)
                ppfc_pkg::CT_GRAY, ppfc_pkg::CT_INDEXED: begin
                    case (cfg_mirror.src_bit_depth)
                        5'd1:    y = {8{pix[0]}};
                        5'd2:    y = {4{pix[1:0]}};
                        5'd4:    y = {2{pix[3:0]}};
                        5'd8:    y = pix[7:0];
                        default: y = pix[15:8];
                    endcase
                    c = {y, y, y, 8'hff};
                end
                ppfc_pkg::CT_RGB: begin
                    c = d8 ? {pix[23:0], 8'hff}
                           : {pix[47:40], pix[31:24], pix[15:8], 8'hff};
                end
                ppfc_pkg::CT_GRAY_ALPHA: begin
                    c = d8 ? {pix[15:8], pix[15:8], pix[15:8], pix[7:0]}
                           : {pix[31:24], pix[31:24], pix[31:24], pix[15:8]};
                end
                default: begin
                    c = d8 ? pix[31:0] : {pix[63:56], pix[47:40], pix[31:24], pix[15:8]};
                end
            endcase
        end
        return c;
    endfunction

    // RGBA8 intermediate to the destination layout. An indexed destination
    // is written as gray of the same depth.
    function automatic logic [63:0] pack_from_rgba8(input logic [31:0] c);
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic [9:0]  sum;
        logic [9:0]  sum3;
        logic [7:0]  y;
        logic        d8;
        logic [63:0] p;
        r = c[31:24];
        g = c[23:16];
        b = c[15:8];
        a = c[7:0];
        sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
        sum3 = sum / 10'd3;
        y = sum3[7:0];
        d8 = (cfg_mirror.dst_bit_depth == 5'd8);
        p = '0;
        case (cfg_mirror.dst_color_type)
            ppfc_pkg::CT_GRAY, ppfc_pkg::CT_INDEXED: begin
                case (cfg_mirror.dst_bit_depth)
                    5'd1:    p = {63'd0, sum >= ppfc_pkg::GRAY1_THRESHOLD};
                    5'd2:    p = {62'd0, y[7:6]};
                    5'd4:    p = {60'd0, y[7:4]};
                    5'd8:    p = {56'd0, y};
                    default: p = {48'd0, y, y};
                endcase
            end
            ppfc_pkg::CT_RGB:        p = d8 ? {40'd0, r, g, b} : {16'd0, r, r, g, g, b, b};
            ppfc_pkg::CT_GRAY_ALPHA: p = d8 ? {48'd0, y, a} : {32'd0, y, y, a, a};
            default:                 p = d8 ? {32'd0, c} : {r, r, g, g, b, b, a, a};
        endcase
        return p;
    endfunction

    function automatic ppfc_pkg::t_out_item convert_pixel(input logic [63:0] pix);
        int                  src_w;
        int                  dst_w;
        ppfc_pkg::t_out_item res;
        src_w = format_width(cfg_mirror.src_bit_depth, cfg_mirror.src_color_type);
        dst_w = format_width(cfg_mirror.dst_bit_depth, cfg_mirror.dst_color_type);
        res = '0;
        if (src_w == 0 || dst_w == 0) begin
            res.format_error = 1'b1;
        end else if (cfg_mirror.src_bit_depth == cfg_mirror.dst_bit_depth &&
                     cfg_mirror.src_color_type == cfg_mirror.dst_color_type) begin
            // Same format on both sides: the pixel passes through, trimmed
            // to its own size.
            res.pixel_out = (src_w >= 64) ? pix : pix & ((64'd1 << src_w) - 64'd1);
        end else begin
            res.pixel_out = pack_from_rgba8(unpack_rgba8(pix));
        end
        return res;
    endfunction

    task automatic queue_drain();
        t_cmd c;
        c = '0;
        c.kind = CMD_DRAIN;
        pixel_cmds.push_back(c);
    endtask

    task automatic queue_mode(input t_idle_mode m);
        t_cmd c;
        c = '0;
        c.kind = CMD_MODE;
        c.mode = m;
        pixel_cmds.push_back(c);
    endtask

    task automatic queue_reg(input logic [2:0] idx, input logic [8:0] val);
        t_cmd c;
        c = '0;
        c.kind = CMD_REG;
        c.reg_idx = idx;
        c.reg_val = val;
        pixel_cmds.push_back(c);
    endtask

    // A new setting is only written once the block has gone quiet.
    task automatic queue_setting(input logic [4:0] sd, input logic [2:0] sct,
                                 input logic [4:0] dd, input logic [2:0] dct,
                                 input logic pp, input logic [8:0] pc,
                                 input logic [8:0] ac);
        queue_drain();
        queue_reg(ppfc_pkg::CFG_SRC_BIT_DEPTH, {4'd0, sd});
        queue_reg(ppfc_pkg::CFG_SRC_COLOR_TYPE, {6'd0, sct});
        queue_reg(ppfc_pkg::CFG_DST_BIT_DEPTH, {4'd0, dd});
        queue_reg(ppfc_pkg::CFG_DST_COLOR_TYPE, {6'd0, dct});
        queue_reg(ppfc_pkg::CFG_PALETTE_PRESENT, {8'd0, pp});
        queue_reg(ppfc_pkg::CFG_PALETTE_COUNT, pc);
        queue_reg(ppfc_pkg::CFG_ALPHA_COUNT, ac);
    endtask

    // Convert item; the palette fields carry noise that must be ignored.
    task automatic queue_convert(input logic [63:0] pix);
        t_cmd c;
        c = '0;
        c.kind = CMD_ITEM;
        c.item.op = ppfc_pkg::OP_CONVERT;
        c.item.pixel_in = pix;
        c.item.table_index = 8'($urandom);
        c.item.table_color = 24'($urandom);
        c.item.table_alpha = 8'($urandom);
        pixel_cmds.push_back(c);
    endtask

    task automatic queue_palette_write(input logic [7:0] idx, input logic [23:0] color,
                                       input logic [7:0] alpha);
        t_cmd c;
        c = '0;
        c.kind = CMD_ITEM;
        c.item.op = ppfc_pkg::OP_TABLE_WRITE;
        c.item.pixel_in = {$urandom, $urandom};
        c.item.table_index = idx;
        c.item.table_color = color;
        c.item.table_alpha = alpha;
        pixel_cmds.push_back(c);
    endtask

    // Mostly the five real colour types, now and then any code from 0 to 6.
    function automatic logic [2:0] pick_color_type();
        logic [2:0] ct;
        case ($urandom_range(5))
            0:       ct = ppfc_pkg::CT_GRAY;
            1:       ct = ppfc_pkg::CT_RGB;
            2:       ct = ppfc_pkg::CT_INDEXED;
            3:       ct = ppfc_pkg::CT_GRAY_ALPHA;
            4:       ct = ppfc_pkg::CT_RGBA;
            default: ct = 3'($urandom_range(6));
        endcase
        return ct;
    endfunction

    // A depth that suits the colour type, apart from now and then any depth from 1 to 16.
    function automatic logic [4:0] pick_depth(input logic [2:0] ct);
        logic [4:0] d;
        if (chance(12)) begin
            d = 5'($urandom_range(1, 16));
        end else if (ct == ppfc_pkg::CT_GRAY) begin
            d = 5'd1 << $urandom_range(4);
        end else if (ct == ppfc_pkg::CT_INDEXED) begin
            d = 5'd1 << $urandom_range(3);
        end else begin
            d = chance(50) ? 5'd8 : 5'd16;
        end
        return d;
    endfunction

    function automatic logic [8:0] pick_count();
        logic [8:0] n;
        case ($urandom_range(3))
            0:       n = 9'd0;
            1:       n = ppfc_pkg::PAL_LIMIT;
            default: n = 9'($urandom_range(256));
        endcase
        return n;
    endfunction

    function automatic logic [63:0] pick_pixel();
        logic [63:0] p;
        case ($urandom_range(9))
            0:       p = '0;
            1:       p = '1;
            default: p = {$urandom, $urandom};
        endcase
        return p;
    endfunction

    // Driver. An item on offer is held until it is taken; otherwise the next
    // command is carried out. A drain waits until no result is outstanding
    // and the pipeline has had time to empty.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            cfg_we <= 1'b0;
            feed_idle <= 1'b0;
        end else if (!(in_valid && !in_ready)) begin
            nx_valid = 1'b0;
            nx_item = in_data;
            nx_we = 1'b0;
            nx_idx = cfg_index;
            nx_val = cfg_data;
            nx_mode = idle_mode;
            if (drain_on) begin
                if (outstanding != 0) begin
                    settle_left = DRAIN_SETTLE;
                end else if (settle_left != 0) begin
                    settle_left = settle_left - 1;
                end else begin
                    drain_on = 1'b0;
                end
            end
            while (!drain_on && pixel_cmds.size() != 0 && pixel_cmds[0].kind == CMD_MODE) begin
                nx_mode = pixel_cmds[0].mode;
                void'(pixel_cmds.pop_front());
            end
            if (!drain_on && pixel_cmds.size() != 0) begin
                case (pixel_cmds[0].kind)
                    CMD_DRAIN: begin
                        drain_on = 1'b1;
                        settle_left = DRAIN_SETTLE;
                        void'(pixel_cmds.pop_front());
                    end
                    CMD_REG: begin
                        nx_we = 1'b1;
                        nx_idx = pixel_cmds[0].reg_idx;
                        nx_val = pixel_cmds[0].reg_val;
                        void'(pixel_cmds.pop_front());
                    end
                    default: begin
                        sender_gap = (nx_mode == MODE_SEND_GAPS) ? chance(46) :
                                     (nx_mode == MODE_BOTH) ? chance(11) : 1'b0;
                        if (!sender_gap) begin
                            nx_valid = 1'b1;
                            nx_item = pixel_cmds[0].item;
                            void'(pixel_cmds.pop_front());
                        end
                    end
                endcase
            end
            in_valid <= nx_valid;
            in_data <= nx_item;
            cfg_we <= nx_we;
            cfg_index <= nx_idx;
            cfg_data <= nx_val;
            idle_mode <= nx_mode;
            feed_idle <= !drain_on && pixel_cmds.size() == 0 && !nx_valid;
        end
    end

    // Monitor. It follows register writes and accepted items to keep its
    // copy of the block up to date, and checks every result taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            cfg_mirror.src_bit_depth <= 5'd8;
            cfg_mirror.src_color_type <= ppfc_pkg::CT_RGBA;
            cfg_mirror.dst_bit_depth <= 5'd8;
            cfg_mirror.dst_color_type <= ppfc_pkg::CT_RGBA;
            cfg_mirror.palette_present <= 1'b0;
            cfg_mirror.palette_count <= 9'd0;
            cfg_mirror.alpha_count <= 9'd0;
            out_ready <= 1'b0;
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    ppfc_pkg::CFG_SRC_BIT_DEPTH:
                        cfg_mirror.src_bit_depth = cfg_data[4:0];
                    ppfc_pkg::CFG_SRC_COLOR_TYPE:
                        cfg_mirror.src_color_type = cfg_data[2:0];
                    ppfc_pkg::CFG_DST_BIT_DEPTH:
                        cfg_mirror.dst_bit_depth = cfg_data[4:0];
                    ppfc_pkg::CFG_DST_COLOR_TYPE:
                        cfg_mirror.dst_color_type = cfg_data[2:0];
                    ppfc_pkg::CFG_PALETTE_PRESENT:
                        cfg_mirror.palette_present = cfg_data[0];
                    ppfc_pkg::CFG_PALETTE_COUNT:
                        cfg_mirror.palette_count = cfg_data;
                    ppfc_pkg::CFG_ALPHA_COUNT:
                        cfg_mirror.alpha_count = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                if (in_data.op == ppfc_pkg::OP_TABLE_WRITE) begin
                    palette_mirror[in_data.table_index] = {in_data.table_color,
                                                           in_data.table_alpha};
                end else begin
                    expected_pixels.push_back(convert_pixel(in_data.pixel_in));
                end
            end
            if (out_valid && out_ready) begin
                result_cnt = result_cnt + 1;
                if (expected_pixels.size() == 0) begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10) begin
                        $display("unexpected result %0d: pixel %h error %b",
                                 result_cnt, out_data.pixel_out, out_data.format_error);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (out_data.pixel_out !== want.pixel_out ||
                        out_data.format_error !== want.format_error) begin
                        err_cnt = err_cnt + 1;
                        if (err_cnt <= 10) begin
                            $display("result %0d: expected pixel %h error %b, got pixel %h error %b",
                                     result_cnt, want.pixel_out, want.format_error,
                                     out_data.pixel_out, out_data.format_error);
                        end
                    end
                end
            end
            outstanding <= expected_pixels.size();
            out_ready <= !((idle_mode == MODE_RECV_STALLS) ? chance(46) :
                           (idle_mode == MODE_BOTH) ? chance(11) : 1'b0);
        end
    end

    initial begin
        int         p;
        int         k;
        logic [2:0] sct;
        logic [2:0] dct;
        logic [4:0] sd;
        logic [4:0] dd;
        logic       pp;
        logic [8:0] pc;
        logic [8:0] ac;

        // Directed items. Out of reset the block passes RGBA8 straight through.
        queue_mode(MODE_FLAT);
        queue_convert('0);
        queue_convert('1);
        queue_convert(64'haaaa_aaaa_aaaa_aaaa);
        queue_palette_write(8'd0, 24'hffffff, 8'h00);
        queue_palette_write(8'd255, 24'h000000, 8'hff);

        // Indexed source with one palette colour: index 255 lies past the
        // colour count and comes out black, with its alpha from the table.
        queue_setting(5'd8, ppfc_pkg::CT_INDEXED, 5'd8, ppfc_pkg::CT_RGBA, 1'b1, 9'd1,
                      ppfc_pkg::PAL_LIMIT);
        queue_convert('0);
        queue_convert('1);

        // No colours and one alpha entry: index 1 is past both counts.
        queue_setting(5'd1, ppfc_pkg::CT_INDEXED, 5'd16, ppfc_pkg::CT_GRAY_ALPHA, 1'b1,
                      9'd0, 9'd1);
        queue_convert(64'd0);
        queue_convert('1);

        // Indexed without a palette reads as gray; 1-bit gray output sits
        // on the threshold of the channel sum.
        queue_setting(5'd2, ppfc_pkg::CT_INDEXED, 5'd1, ppfc_pkg::CT_GRAY, 1'b0, 9'd0, 9'd0);
        queue_convert(64'd3);
        queue_convert(64'd2);
        queue_convert(64'd1);
        queue_convert(64'hffff_ffff_ffff_fffc);

        // Unsupported source, then unsupported destination.
        queue_setting(5'd4, ppfc_pkg::CT_RGB, 5'd16, ppfc_pkg::CT_RGBA, 1'b0, 9'd0, 9'd0);
        queue_convert('1);
        queue_convert('0);
        queue_setting(5'd8, ppfc_pkg::CT_GRAY, 5'd8, CT_RESERVED, 1'b0, 9'd0, 9'd0);
        queue_convert('1);

        // Same format at the widest and at gray 16.
        queue_setting(5'd16, ppfc_pkg::CT_RGBA, 5'd16, ppfc_pkg::CT_RGBA, 1'b0, 9'd0, 9'd0);
        queue_convert('1);
        queue_setting(5'd16, ppfc_pkg::CT_GRAY, 5'd16, ppfc_pkg::CT_GRAY, 1'b1,
                      ppfc_pkg::PAL_LIMIT, ppfc_pkg::PAL_LIMIT);
        queue_convert(64'hffff_ffff_ffff_1234);

        // Fill the whole palette so that later random indexes only ever
        // read entries that have been written.
        queue_mode(MODE_BOTH);
        for (k = 0; k < ppfc_pkg::PALETTE_DEPTH; k++) begin
            queue_palette_write(k[7:0], 24'($urandom), 8'($urandom));
        end

        // Random settings, each with a run of items under one idling style.
        for (p = 0; p < 20; p++) begin
            sct = pick_color_type();
            sd = pick_depth(sct);
            if (chance(20)) begin
                dct = sct;
                dd = sd;
            end else begin
                dct = pick_color_type();
                dd = pick_depth(dct);
            end
            pp = 1'($urandom_range(1));
            pc = pick_count();
            ac = pick_count();
            if (p == 0) begin
                sct = ppfc_pkg::CT_INDEXED;
                sd = 5'd8;
                dct = ppfc_pkg::CT_RGBA;
                dd = 5'd16;
                pp = 1'b1;
                pc = ppfc_pkg::PAL_LIMIT;
                ac = ppfc_pkg::PAL_LIMIT;
            end else if (p == 1) begin
                sct = ppfc_pkg::CT_INDEXED;
                sd = 5'd8;
                dct = ppfc_pkg::CT_GRAY;
                dd = 5'd16;
                pp = 1'b1;
                pc = 9'd0;
                ac = 9'd0;
            end
            queue_setting(sd, sct, dd, dct, pp, pc, ac);
            queue_mode(t_idle_mode'(p % 4));
            for (k = 0; k < 24; k++) begin
                if (chance(3)) begin
                    queue_drain();
                end
                if (chance(15)) begin
                    queue_palette_write(8'($urandom), 24'($urandom), 8'($urandom));
                end else begin
                    queue_convert(pick_pixel());
                end
            end
        end
        queue_drain();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!(feed_idle && !in_valid)) @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
        #1;
        if (expected_pixels.size() != 0) begin
            $display("%0d expected results never arrived", expected_pixels.size());
        end
        if (err_cnt == 0 && expected_pixels.size() == 0) begin
            $display("png_pixel_format_converter test passed");
        end else begin
            $display("png_pixel_format_converter test failed");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("run limit reached with %0d results outstanding", expected_pixels.size());
        $display("png_pixel_format_converter test failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/ppfc_pkg.sv
hw/rtl/ppfc_palette_ram.sv
hw/rtl/ppfc_reader.sv
hw/rtl/ppfc_writer.sv
hw/rtl/png_pixel_format_converter.sv
test/png_pixel_format_converter_tb.sv
